### sv/msa_pkg.sv
// ----------------------------------------------------------------------------
// msa_pkg
// Shared constants, codes and control types of the max-gap seat allocator.
// ----------------------------------------------------------------------------
package msa_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int CFG_W     = 11;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_BAD_RELEASE = 2'd2
  } stat_code_t;

  typedef enum logic {
    REQ_ALLOC   = 1'b0,
    REQ_RELEASE = 1'b1
  } req_code_t;

  typedef struct packed {
    logic capture;
    logic scan_step;
    logic commit_alloc;
    logic commit_rel;
    logic clear_step;
  } dp_cmd_t;

  typedef struct packed {
    logic in_rel;
    logic scan_last;
    logic clear_last;
    logic out_busy;
  } dp_stat_t;

endpackage

### sv/msa_ctrl.sv
// ----------------------------------------------------------------------------
// msa_ctrl
// Sequencer for map clearing, allocate scans and releases.
// ----------------------------------------------------------------------------
module msa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  msa_pkg::dp_stat_t stat,
  output msa_pkg::dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_CLEAR     = 5'b00001,
    S_IDLE      = 5'b00010,
    S_SCAN      = 5'b00100,
    S_ALLOC_END = 5'b01000,
    S_REL_END   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = stat.in_rel ? S_REL_END : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_ALLOC_END;
        end
      end
      S_ALLOC_END: begin
        if (!stat.out_busy) begin
          cmd.commit_alloc = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_REL_END: begin
        if (!stat.out_busy) begin
          cmd.commit_rel = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

### sv/msa_dp.sv
// ----------------------------------------------------------------------------
// msa_dp
// Occupancy map, gap scan, row size register and result register.
// ----------------------------------------------------------------------------
module msa_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [msa_pkg::CFG_W-1:0]    num_seats,
  input  logic                         req_type,
  input  logic [msa_pkg::SLOT_W-1:0]   release_slot,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [msa_pkg::SLOT_W-1:0]   assigned_slot,
  output logic [1:0]                   status,
  input  msa_pkg::dp_cmd_t             cmd,
  output msa_pkg::dp_stat_t            stat
);

  logic                       map_mem [msa_pkg::MAX_SLOTS];
  logic                       rd_data;
  logic                       rd_en;
  logic [msa_pkg::SLOT_W-1:0] rd_addr;
  logic                       wr_en;
  logic                       wr_data;
  logic [msa_pkg::SLOT_W-1:0] wr_addr;

  logic [msa_pkg::CFG_W-1:0]  seats;
  logic [msa_pkg::CNT_W-1:0]  row_n;
  logic [msa_pkg::SLOT_W-1:0] rel_slot;
  logic [msa_pkg::SLOT_W-1:0] clr_cnt;

  logic [msa_pkg::CNT_W-1:0]  cur;
  logic [msa_pkg::CNT_W-1:0]  prev_p1;
  logic [msa_pkg::CNT_W-1:0]  best_dist;
  logic [msa_pkg::SLOT_W-1:0] best_slot;
  logic                       found;

  logic                       at_end;
  logic                       occ_here;
  logic                       gap_end;
  logic [msa_pkg::CNT_W-1:0]  gap_len;
  logic [msa_pkg::CNT_W-1:0]  half;
  logic [msa_pkg::CNT_W-1:0]  gap_dist;
  logic [msa_pkg::SLOT_W-1:0] cand_slot;
  logic                       rel_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      seats <= msa_pkg::CFG_W'(msa_pkg::MAX_SLOTS);
    end else if (cfg_valid) begin
      seats <= num_seats;
    end
  end

  always_comb begin
    if (seats == '0) begin
      row_n = msa_pkg::CNT_W'(1);
    end else if (msa_pkg::CNT_W'(seats) > msa_pkg::CNT_W'(msa_pkg::MAX_SLOTS)) begin
      row_n = msa_pkg::CNT_W'(msa_pkg::MAX_SLOTS);
    end else begin
      row_n = msa_pkg::CNT_W'(seats);
    end
  end

  assign at_end   = (cur == row_n);
  assign occ_here = at_end || rd_data;
  assign gap_len  = cur - prev_p1;
  assign gap_end  = occ_here && (gap_len != '0);
  assign half     = (gap_len + msa_pkg::CNT_W'(1)) >> 1;

  always_comb begin
    priority if (prev_p1 == '0) begin
      gap_dist  = cur;
      cand_slot = '0;
    end else if (at_end) begin
      gap_dist  = gap_len;
      cand_slot = msa_pkg::SLOT_W'(row_n - msa_pkg::CNT_W'(1));
    end else begin
      gap_dist  = half;
      cand_slot = msa_pkg::SLOT_W'(prev_p1 - msa_pkg::CNT_W'(1) + half);
    end
  end

  assign rel_ok = ({1'b0, rel_slot} < row_n) && rd_data;

  always_comb begin
    rd_en   = cmd.capture || cmd.scan_step;
    rd_addr = msa_pkg::SLOT_W'(cur + msa_pkg::CNT_W'(1));
    if (cmd.capture) begin
      rd_addr = (req_type == msa_pkg::REQ_RELEASE) ? release_slot : '0;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = 1'b0;
    wr_addr = clr_cnt;
    priority if (cmd.clear_step) begin
      wr_en = 1'b1;
    end else if (cmd.commit_alloc) begin
      wr_en   = found;
      wr_data = 1'b1;
      wr_addr = best_slot;
    end else if (cmd.commit_rel) begin
      wr_en   = rel_ok;
      wr_addr = rel_slot;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= map_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + msa_pkg::SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rel_slot  <= release_slot;
      cur       <= '0;
      prev_p1   <= '0;
      best_dist <= '0;
      best_slot <= '0;
      found     <= 1'b0;
    end else if (cmd.scan_step) begin
      cur <= cur + msa_pkg::CNT_W'(1);
      if (occ_here) begin
        prev_p1 <= cur + msa_pkg::CNT_W'(1);
      end
      if (gap_end && (gap_dist > best_dist)) begin
        best_dist <= gap_dist;
        best_slot <= cand_slot;
        found     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit_alloc || cmd.commit_rel) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_alloc) begin
      assigned_slot <= found ? best_slot : '0;
      status        <= found ? msa_pkg::ST_OK : msa_pkg::ST_FULL;
    end else if (cmd.commit_rel) begin
      assigned_slot <= '0;
      status        <= rel_ok ? msa_pkg::ST_OK : msa_pkg::ST_BAD_RELEASE;
    end
  end

  assign stat.in_rel     = (req_type == msa_pkg::REQ_RELEASE);
  assign stat.scan_last  = at_end;
  assign stat.clear_last = (clr_cnt == msa_pkg::SLOT_W'(msa_pkg::MAX_SLOTS - 1));
  assign stat.out_busy   = out_valid && out_stall;

endmodule

### sv/max_gap_seat_allocator.sv
// ----------------------------------------------------------------------------
// max_gap_seat_allocator
// Slot allocator that seats each allocate request as far as possible from
// its nearest occupied neighbor, with release of named slots.
// ----------------------------------------------------------------------------
// An allocate request scans the occupancy memory up to the effective row size,
// one slot per cycle, because it reads through a single read port; a release
// request needs no scan. After reset the block stalls its request input while
// it clears the occupancy memory, but it takes row size writes at any time.
// One request is in work at a time, and a new request is taken while the
// previous result waits.
module max_gap_seat_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [msa_pkg::CFG_W-1:0]  num_seats,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       req_type,
  input  logic [msa_pkg::SLOT_W-1:0] release_slot,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [msa_pkg::SLOT_W-1:0] assigned_slot,
  output logic [1:0]                 status
);

  msa_pkg::dp_cmd_t  cmd;
  msa_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  msa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  msa_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .num_seats     (num_seats),
    .req_type      (req_type),
    .release_slot  (release_slot),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .assigned_slot (assigned_slot),
    .status        (status),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

### sv/msa_checker.sv
// ----------------------------------------------------------------------------
// msa_checker
// Port-level checks of the max-gap seat allocator, bound to the top level.
// ----------------------------------------------------------------------------
module msa_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [msa_pkg::CFG_W-1:0]  num_seats,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       req_type,
  input logic [msa_pkg::SLOT_W-1:0] release_slot,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [msa_pkg::SLOT_W-1:0] assigned_slot,
  input logic [1:0]                 status
);

  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("Request input open right after reset.");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("Second request taken while one is in work.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(assigned_slot) && $stable(status)))
    else $error("Stalled result changed.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == msa_pkg::ST_OK || status == msa_pkg::ST_FULL ||
                   status == msa_pkg::ST_BAD_RELEASE))
    else $error("Undefined status code.");

  a_error_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != msa_pkg::ST_OK) |-> (assigned_slot == '0))
    else $error("Rejected request reports a nonzero slot.");

endmodule

bind max_gap_seat_allocator msa_checker u_msa_checker (.*);

### tb/max_gap_seat_allocator_tb.sv
// ----------------------------------------------------------------------------
// max_gap_seat_allocator_tb
// Self-checking testbench of the max-gap seat allocator. A table of directed
// requests covers an empty row, both row ends, inner midpoints, full rows,
// rejected releases, and row sizes of 0 and above the built maximum. Random
// phases follow over many row sizes, mostly small ones. Every accepted request
// runs through a local occupancy model, and each result is compared with the
// oldest outstanding expectation. Both sides idle at random, with one long
// output hold-off and one input pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module max_gap_seat_allocator_tb;

  localparam int          NUM_PHASES  = 19;
  localparam int          DIR_STEPS   = 26;
  localparam int          HOLD_PHASE  = 4;
  localparam int          PAUSE_PHASE = 7;
  localparam int          HOLD_CYCLES = 300;
  localparam int          DRAIN_WAIT  = 1100;
  localparam int unsigned CYCLE_LIMIT = 2_500_000;

  typedef struct packed {
    logic [msa_pkg::SLOT_W-1:0] slot;
    msa_pkg::stat_code_t        stat;
  } seat_result_t;

  typedef struct packed {
    logic                       is_cfg;
    msa_pkg::req_code_t         req;
    logic [msa_pkg::SLOT_W-1:0] slot;
    logic [msa_pkg::CFG_W-1:0]  rows;
    logic                       typed;
    logic [msa_pkg::SLOT_W-1:0] exp_slot;
    msa_pkg::stat_code_t        exp_stat;
  } step_row_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [msa_pkg::CFG_W-1:0]  num_seats;
  logic                       in_valid;
  logic                       in_stall;
  logic                       req_type;
  logic [msa_pkg::SLOT_W-1:0] release_slot;
  logic                       out_valid;
  logic                       out_stall;
  logic [msa_pkg::SLOT_W-1:0] assigned_slot;
  logic [1:0]                 status;

  logic                      seat_taken [msa_pkg::MAX_SLOTS];
  logic [msa_pkg::CFG_W-1:0] row_setting;
  seat_result_t              expected_seats [$];

  bit          idle_on;
  bit          hold_out_pending;
  int          errors;
  int          requests_sent;
  int          row_writes;
  int          refused_full;
  int          refused_release;
  int unsigned cycle_count;

  step_row_t dir_steps [DIR_STEPS];
  int        phase_rows [NUM_PHASES];
  int        phase_items [NUM_PHASES];

  max_gap_seat_allocator DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .num_seats    (num_seats),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .release_slot (release_slot),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .assigned_slot(assigned_slot),
    .status       (status)
  );

  always #5 clk = ~clk;

  function automatic int live_rows();
    int n;
    n = int'(row_setting);
    if (n == 0) begin
      n = 1;
    end
    if (n > msa_pkg::MAX_SLOTS) begin
      n = msa_pkg::MAX_SLOTS;
    end
    return n;
  endfunction

  function automatic seat_result_t predict_seat(input msa_pkg::req_code_t req,
                                                input logic [msa_pkg::SLOT_W-1:0] slot);
    seat_result_t res;
    int n, i, left, gap, cand, best_gap, best_seat;
    n = live_rows();
    res.slot = '0;
    res.stat = msa_pkg::ST_OK;
    if (req == msa_pkg::REQ_RELEASE) begin
      if (int'(slot) >= n || !seat_taken[slot]) begin
        res.stat = msa_pkg::ST_BAD_RELEASE;
      end else begin
        seat_taken[slot] = 1'b0;
      end
      return res;
    end
    left = -1;
    best_gap = 0;
    best_seat = -1;
    for (i = 0; i <= n; i++) begin
      if (i == n || seat_taken[i]) begin
        if (i - left > 1) begin
          if (left < 0) begin
            gap = i;
            cand = 0;
          end else if (i == n) begin
            gap = i - left - 1;
            cand = n - 1;
          end else begin
            gap = (i - left) / 2;
            cand = left + gap;
          end
          if (gap > best_gap) begin
            best_gap = gap;
            best_seat = cand;
          end
        end
        left = i;
      end
    end
    if (best_seat < 0) begin
      res.stat = msa_pkg::ST_FULL;
    end else begin
      seat_taken[best_seat] = 1'b1;
      res.slot = best_seat[msa_pkg::SLOT_W-1:0];
    end
    return res;
  endfunction

  function automatic int pick_taken(input int n);
    int taken [$];
    int i;
    for (i = 0; i < n; i++) begin
      if (seat_taken[i]) begin
        taken.push_back(i);
      end
    end
    if (taken.size() == 0) begin
      return -1;
    end
    return taken[$urandom_range(0, taken.size() - 1)];
  endfunction

  task automatic offer_request(input msa_pkg::req_code_t req,
                               input logic [msa_pkg::SLOT_W-1:0] slot,
                               input bit typed,
                               input logic [msa_pkg::SLOT_W-1:0] exp_slot,
                               input msa_pkg::stat_code_t exp_stat);
    seat_result_t pred;
    seat_result_t fixed;
    @(negedge clk);
    in_valid <= 1'b1;
    req_type <= req;
    release_slot <= slot;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    pred = predict_seat(req, slot);
    fixed.slot = exp_slot;
    fixed.stat = exp_stat;
    expected_seats.push_back(typed ? fixed : pred);
    requests_sent++;
  endtask

  task automatic pause_offer(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_seats.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic retune_rows(input logic [msa_pkg::CFG_W-1:0] rows);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    num_seats <= rows;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    row_setting = rows;
    row_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time,
               expected_seats.size());
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    seat_result_t exp;
    if (!rst && out_valid && !out_stall) begin
      if (expected_seats.size() == 0) begin
        $display("%0t: result with no request outstanding, slot %0d status %0d",
                 $time, assigned_slot, status);
        errors++;
      end else begin
        exp = expected_seats.pop_front();
        if (assigned_slot !== exp.slot) begin
          $display("%0t: assigned_slot mismatch, expected %0d, got %0d",
                   $time, exp.slot, assigned_slot);
          errors++;
        end
        if (status !== exp.stat) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, exp.stat, status);
          errors++;
        end
        case (exp.stat)
          msa_pkg::ST_FULL:        refused_full++;
          msa_pkg::ST_BAD_RELEASE: refused_release++;
          default: begin
          end
        endcase
      end
    end
  end

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out_pending) begin
        hold_out_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(1, 6) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int ph, k, n, pick, taken;
    clk = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    num_seats = '0;
    in_valid = 1'b0;
    req_type = msa_pkg::REQ_ALLOC;
    release_slot = '0;
    idle_on = 1'b1;
    hold_out_pending = 1'b0;
    foreach (seat_taken[i]) begin
      seat_taken[i] = 1'b0;
    end
    row_setting = msa_pkg::CFG_W'(msa_pkg::MAX_SLOTS);

    dir_steps = '{
      '{1'b0, msa_pkg::REQ_ALLOC,   10'd0,    11'd0,    1'b1, 10'd0,    msa_pkg::ST_OK},
      '{1'b0, msa_pkg::REQ_ALLOC,   10'h3FF,  11'd0,    1'b1, 10'd1023, msa_pkg::ST_OK},
      '{1'b0, msa_pkg::REQ_ALLOC,   10'd0,    11'd0,    1'b1, 10'd511,  msa_pkg::ST_OK},
      '{1'b0, msa_pkg::REQ_RELEASE, 10'd1023, 11'd0,    1'b1, 10'd0,    msa_pkg::ST_OK},
      '{1'b0, msa_pkg::REQ_RELEASE, 10'd1023, 11'd0,    1'b1, 10'd0,
        msa_pkg::ST_BAD_RELEASE},
      '{1'b0, msa_pkg::REQ_RELEASE, 10'd0,    11'd0,    1'b1, 10'd0,    msa_pkg::ST_OK},
      '{1'b0, msa_pkg::REQ_RELEASE, 10'd0,    11'd0,    1'b1, 10'd0,
        msa_pkg::ST_BAD_RELEASE},
      '{1'b0, msa_pkg::REQ_ALLOC,   10'd0,    11'd0,    1'b0, 10'd0,    msa_pkg::ST_OK},
      '{1'b1, msa_pkg::REQ_ALLOC,   10'd0,    11'd0,    1'b0, 10'd0,    msa_pkg::ST_OK},
      '{1'b0, msa_pkg::REQ_ALLOC,   10'd0,    11'd0,    1'b1, 10'd0,    msa_pkg::ST_OK},
      '{1'b0, msa_pkg::REQ_ALLOC,   10'd0,    11'd0,    1'b1, 10'd0,    msa_pkg::ST_FULL},
      '{1'b0, msa_pkg::REQ_RELEASE, 10'd511,  11'd0,    1'b1, 10'd0,
        msa_pkg::ST_BAD_RELEASE},
      '{1'b0, msa_pkg::REQ_RELEASE, 10'd0,    11'd0,    1'b1, 10'd0,    msa_pkg::ST_OK},
      '{1'b1, msa_pkg::REQ_ALLOC,   10'd0,    11'd2047, 1'b0, 10'd0,    msa_pkg::ST_OK},
      '{1'b0, msa_pkg::REQ_RELEASE, 10'd511,  11'd0,    1'b1, 10'd0,    msa_pkg::ST_OK},
      '{1'b1, msa_pkg::REQ_ALLOC,   10'd0,    11'd2,    1'b0, 10'd0,    msa_pkg::ST_OK},
      '{1'b0, msa_pkg::REQ_ALLOC,   10'd0,    11'd0,    1'b1, 10'd0,    msa_pkg::ST_OK},
      '{1'b0, msa_pkg::REQ_ALLOC,   10'd0,    11'd0,    1'b1, 10'd1,    msa_pkg::ST_OK},
      '{1'b0, msa_pkg::REQ_ALLOC,   10'd0,    11'd0,    1'b1, 10'd0,    msa_pkg::ST_FULL},
      '{1'b0, msa_pkg::REQ_RELEASE, 10'd1,    11'd0,    1'b1, 10'd0,    msa_pkg::ST_OK},
      '{1'b0, msa_pkg::REQ_RELEASE, 10'd1023, 11'd0,    1'b1, 10'd0,
        msa_pkg::ST_BAD_RELEASE},
      '{1'b1, msa_pkg::REQ_ALLOC,   10'd0,    11'd5,    1'b0, 10'd0,    msa_pkg::ST_OK},
      '{1'b0, msa_pkg::REQ_ALLOC,   10'd0,    11'd0,    1'b0, 10'd0,    msa_pkg::ST_OK},
      '{1'b0, msa_pkg::REQ_ALLOC,   10'd0,    11'd0,    1'b0, 10'd0,    msa_pkg::ST_OK},
      '{1'b0, msa_pkg::REQ_RELEASE, 10'h2AA,  11'd0,    1'b1, 10'd0,
        msa_pkg::ST_BAD_RELEASE},
      '{1'b0, msa_pkg::REQ_RELEASE, 10'h155,  11'd0,    1'b1, 10'd0,
        msa_pkg::ST_BAD_RELEASE}
    };
    phase_rows  = '{5, 1, 2, 3, 4, 7, 8, 12, 16, 31, 64, 100, 0, 17, 6, 2047, 1025, 33, 9};
    phase_items = '{30, 15, 25, 30, 30, 40, 40, 40, 40, 40, 40, 30, 10, 40, 40, 12, 8,
                    40, 20};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (k = 0; k < DIR_STEPS; k++) begin
      if (dir_steps[k].is_cfg) begin
        retune_rows(dir_steps[k].rows);
      end else begin
        offer_request(dir_steps[k].req, dir_steps[k].slot, dir_steps[k].typed,
                      dir_steps[k].exp_slot, dir_steps[k].exp_stat);
      end
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      retune_rows(msa_pkg::CFG_W'(phase_rows[ph]));
      idle_on = (ph % 4 != 3) && (ph < NUM_PHASES - 2);
      if (ph == HOLD_PHASE) begin
        hold_out_pending = 1'b1;
      end
      for (k = 0; k < phase_items[ph]; k++) begin
        if (ph == PAUSE_PHASE && k == phase_items[ph] / 2) begin
          settle();
        end
        if (idle_on && $urandom_range(0, 3) == 0) begin
          pause_offer($urandom_range(1, 6));
        end
        n = live_rows();
        pick = $urandom_range(0, 99);
        taken = pick_taken(n);
        if (pick < 55) begin
          offer_request(msa_pkg::REQ_ALLOC, msa_pkg::SLOT_W'($urandom_range(0, 1023)),
                        1'b0, '0, msa_pkg::ST_OK);
        end else if (pick < 88 && taken >= 0) begin
          offer_request(msa_pkg::REQ_RELEASE, msa_pkg::SLOT_W'(taken),
                        1'b0, '0, msa_pkg::ST_OK);
        end else if (pick < 94) begin
          offer_request(msa_pkg::REQ_RELEASE, msa_pkg::SLOT_W'($urandom_range(0, n - 1)),
                        1'b0, '0, msa_pkg::ST_OK);
        end else begin
          offer_request(msa_pkg::REQ_RELEASE, msa_pkg::SLOT_W'($urandom_range(0, 1023)),
                        1'b0, '0, msa_pkg::ST_OK);
        end
      end
    end

    settle();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d requests across %0d row size writes, sizes 0 to 2047.",
             requests_sent, row_writes);
    $display("Refusals seen: %0d on a full row, %0d on a bad release.",
             refused_full, refused_release);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
